FILE: rtl/bba_pkg.sv
`default_nettype none

package bba_pkg;

    localparam int ADDRESSABLE_BYTES = 8192;

    localparam logic [1:0] ACT_FIND  = 2'd0;
    localparam logic [1:0] ACT_WRITE = 2'd1;
    localparam logic [1:0] ACT_QUERY = 2'd2;

    typedef enum logic [1:0] {
        RK_ZERO,
        RK_FOUND,
        RK_WBIT,
        RK_QBIT
    } res_kind_t;

    typedef struct packed {
        logic      clear_step;
        logic      accept;
        logic      rd_en;
        logic      scan_next;
        logic      wr_en;
        logic      hint_found;
        logic      hint_full;
        logic      load_out;
        res_kind_t kind;
    } ctl_cmd_t;

    typedef struct packed {
        logic clr_last;
        logic is_find;
        logic is_write;
        logic is_query;
        logic in_map;
        logic map_full;
        logic byte_free;
        logic scan_last;
    } dp_status_t;

endpackage

`default_nettype wire

FILE: rtl/bba_datapath.sv
`default_nettype none

module bba_datapath
    import bba_pkg::*;
#(
    parameter int BITMAP_BYTES = 8192
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire ctl_cmd_t    cmd,
    output dp_status_t       st,
    input  wire logic [1:0]  action,
    input  wire logic [15:0] blk_num,
    input  wire logic        bit_value,
    output logic [15:0]      free_block,
    output logic             found,
    output logic             bit_state
);

    localparam int AW = (BITMAP_BYTES > 1) ? $clog2(BITMAP_BYTES) : 1;
    localparam int SCAN_BYTES = (BITMAP_BYTES < ADDRESSABLE_BYTES) ?
                                BITMAP_BYTES : ADDRESSABLE_BYTES;
    localparam int HW = $clog2(SCAN_BYTES + 1);
    localparam logic [16:0] MAP_BYTES_W = 17'(BITMAP_BYTES);

    logic [7:0]    mem [BITMAP_BYTES];
    logic [7:0]    rdata_reg;
    logic [AW-1:0] clr_cnt_reg;
    logic [HW-1:0] hint_reg;
    logic [HW-1:0] scan_reg;
    logic [1:0]    action_reg;
    logic [15:0]   blk_reg;
    logic          val_reg;
    logic [15:0]   free_block_reg;
    logic          found_reg;
    logic          bit_state_reg;

    logic [12:0]   blk_byte;
    logic [AW-1:0] blk_addr;
    logic [AW-1:0] rd_addr;
    logic [2:0]    bit_pos;
    logic [7:0]    bit_mask;
    logic [7:0]    new_byte;

    function automatic logic [2:0] first_zero(input logic [7:0] b);
        logic [2:0] r;
        r = '0;
        for (int k = 7; k >= 0; k--)
        begin
            if (!b[7-k])
            begin
                r = 3'(k);
            end
        end
        return r;
    endfunction

    assign blk_byte = blk_reg[15:3];
    assign blk_addr = AW'(blk_byte);
    assign rd_addr  = st.is_find ? AW'(scan_reg) : blk_addr;
    assign bit_pos  = ~blk_reg[2:0];
    assign bit_mask = 8'h01 << bit_pos;
    assign new_byte = val_reg ? (rdata_reg | bit_mask) : (rdata_reg & ~bit_mask);

    assign st.clr_last  = (clr_cnt_reg == AW'(BITMAP_BYTES - 1));
    assign st.is_find   = (action_reg == ACT_FIND);
    assign st.is_write  = (action_reg == ACT_WRITE);
    assign st.is_query  = (action_reg == ACT_QUERY);
    assign st.in_map    = (17'(blk_byte) < MAP_BYTES_W);
    assign st.map_full  = (hint_reg == HW'(SCAN_BYTES));
    assign st.byte_free = (rdata_reg != 8'hFF);
    assign st.scan_last = (scan_reg == HW'(SCAN_BYTES - 1));

    // bitmap memory: one write, one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (cmd.clear_step)
        begin
            mem[clr_cnt_reg] <= '0;
        end
        else if (cmd.wr_en)
        begin
            mem[blk_addr] <= new_byte;
        end
        if (cmd.rd_en)
        begin
            rdata_reg <= mem[rd_addr];
        end
    end

    // hint: every byte below it is fully used
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_cnt_reg <= '0;
            hint_reg    <= '0;
        end
        else
        begin
            if (cmd.clear_step)
            begin
                clr_cnt_reg <= clr_cnt_reg + AW'(1);
            end
            if (cmd.hint_found)
            begin
                hint_reg <= scan_reg;
            end
            else if (cmd.hint_full)
            begin
                hint_reg <= HW'(SCAN_BYTES);
            end
            else if (cmd.wr_en && !val_reg && (17'(blk_byte) < 17'(hint_reg)))
            begin
                hint_reg <= HW'(blk_byte);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            action_reg <= action;
            blk_reg    <= blk_num;
            val_reg    <= bit_value;
            scan_reg   <= hint_reg;
        end
        else if (cmd.scan_next)
        begin
            scan_reg <= scan_reg + HW'(1);
        end
        if (cmd.load_out)
        begin
            unique case (cmd.kind)
                RK_ZERO:
                begin
                    free_block_reg <= '0;
                    found_reg      <= 1'b0;
                    bit_state_reg  <= 1'b0;
                end
                RK_FOUND:
                begin
                    free_block_reg <= 16'({scan_reg, first_zero(rdata_reg)});
                    found_reg      <= 1'b1;
                    bit_state_reg  <= 1'b0;
                end
                RK_WBIT:
                begin
                    free_block_reg <= '0;
                    found_reg      <= 1'b0;
                    bit_state_reg  <= val_reg;
                end
                RK_QBIT:
                begin
                    free_block_reg <= '0;
                    found_reg      <= 1'b0;
                    bit_state_reg  <= rdata_reg[bit_pos];
                end
                default:
                begin
                    free_block_reg <= '0;
                    found_reg      <= 1'b0;
                    bit_state_reg  <= 1'b0;
                end
            endcase
        end
    end

    assign free_block = free_block_reg;
    assign found      = found_reg;
    assign bit_state  = bit_state_reg;

endmodule

`default_nettype wire

FILE: rtl/bba_ctrl.sv
`default_nettype none

module bba_ctrl
    import bba_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire dp_status_t st,
    output ctl_cmd_t        cmd,
    input  wire logic       s_tvalid,
    output logic            s_tready,
    output logic            m_tvalid,
    input  wire logic       m_tready
);

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_DISPATCH,
        ST_READ,
        ST_CHECK,
        ST_DONE
    } state_t;

    state_t    state_reg, state_next;
    res_kind_t kind_reg, kind_next;
    logic      out_valid_reg, out_valid_next;

    always_comb
    begin
        state_next     = state_reg;
        kind_next      = kind_reg;
        out_valid_next = out_valid_reg && !m_tready;
        cmd            = '0;
        cmd.kind       = kind_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                cmd.clear_step = 1'b1;
                if (st.clr_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    cmd.accept = 1'b1;
                    state_next = ST_DISPATCH;
                end
            end
            ST_DISPATCH:
            begin
                priority if (st.is_find)
                begin
                    if (st.map_full)
                    begin
                        kind_next  = RK_ZERO;
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        state_next = ST_READ;
                    end
                end
                else if ((st.is_write || st.is_query) && st.in_map)
                begin
                    state_next = ST_READ;
                end
                else
                begin
                    kind_next  = RK_ZERO;
                    state_next = ST_DONE;
                end
            end
            ST_READ:
            begin
                cmd.rd_en  = 1'b1;
                state_next = ST_CHECK;
            end
            ST_CHECK:
            begin
                priority if (st.is_find)
                begin
                    priority if (st.byte_free)
                    begin
                        cmd.hint_found = 1'b1;
                        kind_next      = RK_FOUND;
                        state_next     = ST_DONE;
                    end
                    else if (st.scan_last)
                    begin
                        cmd.hint_full = 1'b1;
                        kind_next     = RK_ZERO;
                        state_next    = ST_DONE;
                    end
                    else
                    begin
                        cmd.scan_next = 1'b1;
                        state_next    = ST_READ;
                    end
                end
                else if (st.is_write)
                begin
                    cmd.wr_en  = 1'b1;
                    kind_next  = RK_WBIT;
                    state_next = ST_DONE;
                end
                else
                begin
                    kind_next  = RK_QBIT;
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    cmd.load_out   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            kind_reg      <= RK_ZERO;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            kind_reg      <= kind_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = out_valid_reg;

`ifndef NO_ASSERTIONS
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("input taken while a request is in progress");

    a_load_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |-> (!out_valid_reg || m_tready))
        else $error("result overwrites an untaken transfer");

    a_write_not_find: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.wr_en |-> (st.is_write && !st.is_find))
        else $error("bitmap write outside a write request");

    a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.scan_next |-> !st.scan_last)
        else $error("scan ran past the last byte");
`endif

endmodule

`default_nettype wire

FILE: rtl/bitmap_block_allocator_core.sv
// Find: reads one bitmap byte at a time, starting at the lowest byte
//   that may hold a free bit (registered memory read, then test of the byte).
// Write / query: memory read, then modify-write or bit test, then result load; a
//   full bitmap (find), a block beyond the bitmap or an unused action skip the read.
// One request in flight; the next is taken while a result waits on the output.
// After reset the bitmap is cleared one byte a cycle first.
`default_nettype none

module bitmap_block_allocator_core
    import bba_pkg::*;
#(
    parameter int BITMAP_BYTES = 8192
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [23:0] s_tdata,   // block_index[15:0], bit_value[16], zero pad
    input  wire logic [1:0]  s_tuser,   // action[1:0]
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [23:0]      m_tdata,   // free_block[15:0], bit_state[16], zero pad
    output logic [0:0]       m_tuser    // found[0]
);

    ctl_cmd_t    cmd;
    dp_status_t  st;
    logic [15:0] free_block;
    logic        found;
    logic        bit_state;

    bba_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .st       (st),
        .cmd      (cmd),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready)
    );

    bba_datapath #(
        .BITMAP_BYTES (BITMAP_BYTES)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .st          (st),
        .action      (s_tuser),
        .blk_num     (s_tdata[15:0]),
        .bit_value   (s_tdata[16]),
        .free_block  (free_block),
        .found       (found),
        .bit_state   (bit_state)
    );

    assign m_tdata = {7'b0, bit_state, free_block};
    assign m_tuser = found;

endmodule

`default_nettype wire

FILE: tb/bitmap_block_allocator_core_tb.sv
`timescale 1ns / 100ps

module bitmap_block_allocator_core_tb;
    import bba_pkg::*;

    localparam int         MAP_BYTES = 8192;
    localparam logic [1:0] ACT_SPARE = 2'd3;

    typedef struct {
        logic [15:0] free_block;
        logic        found;
        logic        bit_state;
    } answer_t;

    class allocator_shadow;
        bit      used_blk [0:65535];
        answer_t pending_answers [$];
        int      fail_count;

        function new();
            fail_count = 0;
        endfunction

        function void find_free(output logic ok, output logic [15:0] blk);
            int scan_blocks;
            scan_blocks = ((MAP_BYTES < ADDRESSABLE_BYTES) ? MAP_BYTES : ADDRESSABLE_BYTES) * 8;
            ok = 1'b0;
            blk = '0;
            for (int i = 0; i < scan_blocks; i++)
            begin
                if (!used_blk[i])
                begin
                    ok = 1'b1;
                    blk = i[15:0];
                    break;
                end
            end
        endfunction

        function void note_request(input logic [1:0] act, input logic [15:0] blk,
                                   input logic val);
            answer_t ans;
            logic    in_map;
            ans.free_block = '0;
            ans.found = 1'b0;
            ans.bit_state = 1'b0;
            in_map = (int'(blk) >> 3) < MAP_BYTES;
            case (act)
                ACT_FIND:
                    find_free(ans.found, ans.free_block);
                ACT_WRITE:
                    if (in_map)
                    begin
                        used_blk[blk] = val;
                        ans.bit_state = val;
                    end
                ACT_QUERY:
                    if (in_map)
                        ans.bit_state = used_blk[blk];
                default: ;
            endcase
            pending_answers.push_back(ans);
        endfunction

        function void check_answer(input logic [15:0] free_block, input logic found,
                                   input logic bit_state);
            answer_t exp_ans;
            if (pending_answers.size() == 0)
            begin
                $display("%0t: unexpected result free_block=%h found=%b bit_state=%b",
                         $time, free_block, found, bit_state);
                fail_count++;
                return;
            end
            exp_ans = pending_answers.pop_front();
            if (free_block !== exp_ans.free_block)
            begin
                $display("%0t: free_block expected %h, got %h",
                         $time, exp_ans.free_block, free_block);
                fail_count++;
            end
            if (found !== exp_ans.found)
            begin
                $display("%0t: found expected %b, got %b", $time, exp_ans.found, found);
                fail_count++;
            end
            if (bit_state !== exp_ans.bit_state)
            begin
                $display("%0t: bit_state expected %b, got %b",
                         $time, exp_ans.bit_state, bit_state);
                fail_count++;
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [23:0] s_tdata;
    logic [1:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [23:0] m_tdata;
    logic [0:0]  m_tuser;

    allocator_shadow shadow = new();
    bit              jitter_on;
    int              stall_left;

    bitmap_block_allocator_core #(
        .BITMAP_BYTES(MAP_BYTES)
    ) DUT (
        .clk     (clk),
        .rst_n   (rst_n),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #60_000_000;
        $display("Some tests failed");
        $finish;
    end

    // one transfer on the request side, with an optional idle burst ahead of it
    task automatic send_request(input logic [1:0] act, input logic [15:0] blk,
                                input logic val);
        @(negedge clk);
        if (jitter_on && $urandom_range(0, 3) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {7'b0, val, blk};
        s_tuser  <= act;
        do
            @(posedge clk);
        while (!s_tready);
        shadow.note_request(act, blk, val);
    endtask

    task automatic alloc_next();
        logic        ok;
        logic [15:0] blk;
        send_request(ACT_FIND, 16'($urandom_range(0, 65535)), 1'($urandom_range(0, 1)));
        shadow.find_free(ok, blk);
        if (ok)
            send_request(ACT_WRITE, blk, 1'b1);
    endtask

    initial
    begin
        m_tready = 1'b0;
        stall_left = 0;
        forever
        begin
            @(negedge clk);
            if (jitter_on && stall_left == 0 && $urandom_range(0, 3) == 0)
                stall_left = $urandom_range(1, 4);
            if (stall_left > 0)
            begin
                m_tready <= 1'b0;
                stall_left--;
            end
            else
                m_tready <= 1'b1;
        end
    end

    always @(posedge clk)
        if (rst_n && m_tvalid && m_tready)
            shadow.check_answer(m_tdata[15:0], m_tuser[0], m_tdata[16]);

    initial
    begin
        int r;
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = ACT_FIND;
        jitter_on = 1'b1;
        repeat (8) @(negedge clk);
        rst_n <= 1'b1;

        // directed
        send_request(ACT_FIND, 16'hFFFF, 1'b1);
        send_request(ACT_QUERY, 16'h0000, 1'b0);
        send_request(ACT_WRITE, 16'h0000, 1'b1);
        send_request(ACT_QUERY, 16'h0000, 1'b0);
        send_request(ACT_FIND, 16'h0000, 1'b0);
        send_request(ACT_WRITE, 16'hFFFF, 1'b1);
        send_request(ACT_QUERY, 16'hFFFF, 1'b1);
        send_request(ACT_WRITE, 16'hFFFF, 1'b0);
        send_request(ACT_WRITE, 16'd7, 1'b1);
        send_request(ACT_WRITE, 16'd8, 1'b1);
        for (int i = 1; i < 7; i++)
            send_request(ACT_WRITE, i[15:0], 1'b1);
        send_request(ACT_FIND, 16'h5555, 1'b1);
        send_request(ACT_SPARE, 16'hFFFF, 1'b1);
        send_request(ACT_QUERY, 16'hFFFF, 1'b0);
        send_request(ACT_WRITE, 16'hAAAA, 1'b1);
        send_request(ACT_QUERY, 16'hAAAA, 1'b0);
        send_request(ACT_QUERY, 16'h5555, 1'b1);
        send_request(ACT_WRITE, 16'h0000, 1'b0);
        send_request(ACT_FIND, 16'h0000, 1'b0);

        // random: mostly allocate / free traffic in the low blocks
        for (int n = 0; n < 1400; n++)
        begin
            if (n == 1150)
                jitter_on = 1'b0;
            r = $urandom_range(0, 99);
            if (r < 35)
                alloc_next();
            else if (r < 50)
                send_request(ACT_WRITE, 16'($urandom_range(0, 1023)), 1'b0);
            else if (r < 60)
                send_request(ACT_QUERY, 16'($urandom_range(0, 1023)),
                             1'($urandom_range(0, 1)));
            else if (r < 70)
                send_request(ACT_QUERY, 16'($urandom_range(0, 65535)),
                             1'($urandom_range(0, 1)));
            else if (r < 85)
                send_request(ACT_WRITE, 16'($urandom_range(0, 65535)),
                             1'($urandom_range(0, 1)));
            else if (r < 95)
                send_request(ACT_FIND, 16'($urandom_range(0, 65535)),
                             1'($urandom_range(0, 1)));
            else
                send_request(ACT_SPARE, 16'($urandom_range(0, 65535)),
                             1'($urandom_range(0, 1)));
        end

        // freeing and finding around the ends of the block range
        send_request(ACT_FIND, 16'h1234, 1'b0);
        send_request(ACT_SPARE, 16'h0000, 1'b0);
        send_request(ACT_QUERY, 16'h8000, 1'b0);
        send_request(ACT_WRITE, 16'hFFFF, 1'b0);
        send_request(ACT_FIND, 16'h0000, 1'b0);
        send_request(ACT_WRITE, 16'h0000, 1'b0);
        send_request(ACT_FIND, 16'h0000, 1'b0);
        send_request(ACT_WRITE, 16'h0000, 1'b1);
        send_request(ACT_FIND, 16'h0000, 1'b0);
        send_request(ACT_WRITE, 16'hFFFF, 1'b1);
        send_request(ACT_FIND, 16'hFFFF, 1'b1);

        @(negedge clk);
        s_tvalid <= 1'b0;
        while (shadow.pending_answers.size() > 0)
            @(posedge clk);
        repeat (50) @(posedge clk);

        if (shadow.fail_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

FILE: filelist.f
rtl/bba_pkg.sv
rtl/bba_datapath.sv
rtl/bba_ctrl.sv
rtl/bitmap_block_allocator_core.sv
tb/bitmap_block_allocator_core_tb.sv
